FILE: hdl/ffha_pkg.sv
// Package for the first-fit heap allocator: sizes, codes, state encoding.
// No dependencies.
`default_nettype none
package ffha_pkg;
  localparam int HEAP_BYTES   = 65536;
  localparam int ALIGN_BYTES  = 8;
  localparam int HEADER_BYTES = 32;
  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int OFF_W  = 16;
  localparam int SIZE_W = 17;
  localparam int ADDR_W = 48;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic              used;
  } entry_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SCAN   = 10'b0000000010,
    S_EVAL   = 10'b0000000100,
    S_SHUP   = 10'b0000001000,
    S_SHDN   = 10'b0000010000,
    S_NEXT   = 10'b0000100000,
    S_PREV   = 10'b0001000000,
    S_DONE   = 10'b0010000000,
    S_OUT    = 10'b0100000000,
    S_RDWAIT = 10'b1000000000
  } state_t;
endpackage
`default_nettype wire

FILE: hdl/ffha_table.sv
// Block table memory: one write port, one registered read port.
// Depends on ffha_pkg.
`default_nettype none
module ffha_table (
  input  wire                   clk,
  input  wire                   we,
  input  wire [ffha_pkg::IDX_W-1:0] waddr,
  input  wire ffha_pkg::entry_t wdata,
  input  wire [ffha_pkg::IDX_W-1:0] raddr,
  output ffha_pkg::entry_t      rdata
);
  import ffha_pkg::*;
  entry_t mem [MAX_BLOCKS];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: sequencer, block table, result register.
// Depends on ffha_pkg and ffha_table.
`default_nettype none
// Rate: one request at a time. The table has a single registered read port,
// so every table read takes an address step (S_RDWAIT), then a data step.
// An allocate scans entry by entry until the first fit; a split then shifts
// the later entries up one slot at a time. A free scans the same way, and
// each merge removes one entry by shifting the later ones down one slot at a
// time. The table holds at most 64 live entries. Release-all and the unused
// mode go straight from idle to the done state. After the result beat is
// taken the sequencer returns to idle by way of the output state. Entry 0
// and the count are fixed up directly on reset and release-all, so no
// clearing pass exists. The in-use bit of entries is never read beyond
// count, so table memory needs no reset. s_tready is low from the accepted
// beat until the sequencer is back in idle with the result register empty.
module first_fit_heap_allocator (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [47:0] cfg_wdata,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [71:0] s_tdata,  // mode[1:0], request_size[18:2], block_address[66:19], zero pad
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [55:0] m_tdata   // result_address[47:0], status[49:48], zero pad
);
  import ffha_pkg::*;

  logic [ADDR_W-1:0] heap_base;
  state_t            state;
  logic [1:0]        mode;
  logic [SIZE_W:0]   asize;
  logic [ADDR_W-1:0] foff;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx, hit, j;
  entry_t            cur;
  logic [ADDR_W-1:0] res_addr;
  logic [1:0]        res_status;
  state_t            ret;
  logic              pdone;     // predecessor merge already done

  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  entry_t            wdata, rdata;

  ffha_table u_tab (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  // entry 0 is patched in a register since reset cannot reach the RAM
  logic   e0_ovr;
  entry_t e0;
  entry_t rd;
  logic [IDX_W-1:0] raddr_q;
  always_comb rd = (e0_ovr && raddr_q == '0) ? e0 : rdata;

  logic [SIZE_W+8:0] need;
  always_comb need = {8'd0, asize} + (SIZE_W+9)'(HEADER_BYTES + ALIGN_BYTES);

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tdata  = {6'd0, res_status, res_addr};

  logic [SIZE_W+1:0] rq;
  always_comb rq = {2'd0, s_tdata[18:2]} + (SIZE_W+2)'(ALIGN_BYTES-1);

  always_ff @(posedge clk) begin
    raddr_q <= raddr;
    if (rst) begin
      heap_base <= '0; state <= S_IDLE; m_tvalid <= 1'b0; count <= CNT_W'(1);
      e0_ovr <= 1'b1;
      e0 <= '{offset: '0, size: SIZE_W'(HEAP_BYTES-HEADER_BYTES), used: 1'b0};
    end else begin
      if (cfg_we) heap_base <= cfg_wdata;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (we && waddr == '0) e0_ovr <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          mode  <= s_tdata[1:0];
          asize <= (SIZE_W+1)'(rq / ALIGN_BYTES * ALIGN_BYTES);
          foff  <= s_tdata[66:19] - heap_base;
          idx   <= '0; res_addr <= '0; res_status <= ST_OK;
          pdone <= 1'b0;
          if (s_tdata[1:0] == MODE_RELEASE) begin
            count <= CNT_W'(1); e0_ovr <= 1'b1;
            e0 <= '{offset: '0, size: SIZE_W'(HEAP_BYTES-HEADER_BYTES), used: 1'b0};
            state <= S_DONE;
          end else if (s_tdata[1:0] == MODE_ALLOC || s_tdata[1:0] == MODE_FREE)
            state <= S_RDWAIT;
          else state <= S_DONE;
          ret <= S_SCAN;
        end
        S_RDWAIT: state <= ret;
        S_SCAN: begin
          cur <= rd;
          if (mode == MODE_ALLOC && !rd.used && {1'b0, rd.size} >= asize) begin
            hit <= idx;
            res_addr <= heap_base + ADDR_W'(rd.offset) + ADDR_W'(HEADER_BYTES);
            if ({9'd0, rd.size} >= need && count < CNT_W'(MAX_BLOCKS)) begin
              j <= count[IDX_W-1:0]; state <= S_RDWAIT; ret <= S_SHUP;
            end else state <= S_EVAL;
          end else if (mode == MODE_FREE && rd.used &&
                       ADDR_W'(rd.offset) + ADDR_W'(HEADER_BYTES) == foff) begin
            // in-use mark is cleared by the write in S_EVAL
            hit <= idx;
            state <= S_EVAL;
          end else if (CNT_W'(idx) + 1'b1 >= count) begin
            res_status <= (mode == MODE_ALLOC) ? ST_NOMEM : ST_BADFREE;
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1; state <= S_RDWAIT;
          end
        end
        S_SHUP: begin
          // rd holds entry j-1, moved to j; at j==hit+1 write the split tail
          if (j == hit + 1'b1) begin
            state <= S_EVAL; count <= count + 1'b1;
            cur <= '{offset: cur.offset, size: asize[SIZE_W-1:0], used: 1'b0};
          end else begin
            j <= j - 1'b1; state <= S_RDWAIT; ret <= S_SHUP;
          end
        end
        S_EVAL: begin
          // write hit entry; for free, go look at neighbours
          if (mode == MODE_ALLOC) state <= S_DONE;
          else if (CNT_W'(hit) + 1'b1 < count) begin
            idx <= hit + 1'b1; state <= S_RDWAIT; ret <= S_NEXT;
          end else if (hit != '0) begin
            idx <= hit - 1'b1; state <= S_RDWAIT; ret <= S_PREV;
          end else state <= S_DONE;
        end
        S_NEXT: begin
          if (!rd.used) begin
            cur.size <= cur.size + SIZE_W'(HEADER_BYTES) + rd.size;
            j <= hit + 1'b1; ret <= S_SHDN; state <= S_RDWAIT;
          end else if (hit != '0) begin
            idx <= hit - 1'b1; state <= S_RDWAIT; ret <= S_PREV;
          end else state <= S_DONE;
        end
        S_PREV: begin
          if (!rd.used) begin
            cur <= '{offset: rd.offset,
                     size: rd.size + SIZE_W'(HEADER_BYTES) + cur.size, used: 1'b0};
            hit <= idx; j <= hit; ret <= S_SHDN; state <= S_RDWAIT;
            pdone <= 1'b1;
          end else state <= S_DONE;
        end
        S_SHDN: begin
          // rd is entry j+1 moved to j, until j+1 reaches count-1
          if (CNT_W'(j) + CNT_W'(2) >= count) begin
            count <= count - 1'b1;
            // after a successor merge, the predecessor is still to be checked
            if (mode == MODE_FREE && hit != '0 && !pdone) begin
              idx <= hit - 1'b1; state <= S_RDWAIT; ret <= S_PREV;
            end else state <= S_DONE;
          end else begin
            j <= j + 1'b1; state <= S_RDWAIT; ret <= S_SHDN;
          end
        end
        S_DONE: begin m_tvalid <= 1'b1; state <= S_OUT; end
        S_OUT:  if (!m_tvalid) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // read address and write port
  always_comb begin
    raddr = idx;
    we = 1'b0; waddr = hit; wdata = cur;
    unique case (state)
      S_SHUP:   raddr = j - 1'b1;
      S_SHDN:   raddr = j + 1'b1;
      S_RDWAIT: begin
        unique case (ret)
          S_SHUP: raddr = j - 1'b1;
          S_SHDN: raddr = j + 1'b1;
          default: raddr = idx;
        endcase
      end
      default: raddr = idx;
    endcase
    unique case (state)
      S_SHUP: begin
        we = 1'b1; waddr = j;
        wdata = (j == hit + 1'b1) ?
          '{offset: OFF_W'(cur.offset + OFF_W'(HEADER_BYTES) + OFF_W'(asize)),
            size: cur.size - asize[SIZE_W-1:0] - SIZE_W'(HEADER_BYTES),
            used: 1'b0} : rd;
      end
      S_EVAL: begin
        we = 1'b1; waddr = hit;
        wdata = '{offset: cur.offset, size: cur.size, used: (mode == MODE_ALLOC)};
      end
      S_NEXT: if (!rd.used) begin
        we = 1'b1; waddr = hit;
        wdata = '{offset: cur.offset,
                  size: cur.size + SIZE_W'(HEADER_BYTES) + rd.size, used: 1'b0};
      end
      S_PREV: if (!rd.used) begin
        we = 1'b1; waddr = idx;
        wdata = '{offset: rd.offset,
                  size: rd.size + SIZE_W'(HEADER_BYTES) + cur.size, used: 1'b0};
      end
      S_SHDN: begin we = 1'b1; waddr = j; wdata = rd; end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_tready) else $error("ready while busy");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(1) && count <= CNT_W'(MAX_BLOCKS)) else $error("count range");
  a_res: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_status != ST_OK |-> res_addr == '0) else $error("addr on error");
`endif
endmodule
`default_nettype wire
